// ===== hdl/ble_pkg.sv =====
// Shared types and constants for the bounded list engine.
package ble_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = IDX_W + 1;

   localparam int REQ_W    = 80;
   localparam int RSP_W    = 88;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [63:0] INT_MIN_64 = 64'hFFFF_FFFF_8000_0000;

   typedef enum logic [2:0] {
      CMD_PUSH  = 3'd0,
      CMD_POP   = 3'd1,
      CMD_GET   = 3'd2,
      CMD_FIND  = 3'd3,
      CMD_MAX   = 3'd4,
      CMD_ERASE = 3'd5,
      CMD_CLEAR = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_FIXUP,
      S_RESP
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic decode;
      logic scan;
      logic fixup;
      logic respond;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_scan;
      logic is_erase;
      logic scan_done;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== hdl/ble_ctrl.sv =====
// Controller state machine for the bounded list engine.
module ble_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  ble_pkg::dp_stat_type stat,
   output ble_pkg::ctl_cmd_type ctl
);

   ble_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ble_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ble_pkg::S_IDLE: begin
            if (req_tvalid) state_in = ble_pkg::S_DECODE;
         end
         ble_pkg::S_DECODE: begin
            state_in = stat.need_scan ? ble_pkg::S_SCAN : ble_pkg::S_RESP;
         end
         ble_pkg::S_SCAN: begin
            if (stat.scan_done) begin
               state_in = stat.is_erase ? ble_pkg::S_FIXUP : ble_pkg::S_RESP;
            end
         end
         ble_pkg::S_FIXUP: begin
            state_in = ble_pkg::S_RESP;
         end
         ble_pkg::S_RESP: begin
            if (stat.out_free) state_in = ble_pkg::S_IDLE;
         end
         default: begin
            state_in = ble_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ble_pkg::S_IDLE: begin
            req_tready = 1'b1;
            ctl.load   = req_tvalid;
         end
         ble_pkg::S_DECODE: ctl.decode  = 1'b1;
         ble_pkg::S_SCAN:   ctl.scan    = 1'b1;
         ble_pkg::S_FIXUP:  ctl.fixup   = 1'b1;
         ble_pkg::S_RESP:   ctl.respond = 1'b1;
         default: begin
            ctl = '0;
         end
      endcase
   end

endmodule

// ===== hdl/ble_dp.sv =====
// Datapath of the bounded list engine: entry memory, count, scan and result registers.
module ble_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  ble_pkg::ctl_cmd_type ctl,
   output ble_pkg::dp_stat_type stat,
   input  logic [2:0]           command,
   input  logic [63:0]          data_value,
   input  logic [7:0]           position,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          read_value,
   output logic [8:0]           found_index,
   output logic [8:0]           entry_count,
   output logic [1:0]           status
);

   localparam int IW = ble_pkg::IDX_W;
   localparam int CW = ble_pkg::CNT_W;

   logic [63:0] mem [ble_pkg::CAPACITY];

   ble_pkg::cmd_type cmd_ff;
   logic [63:0] value_ff;
   logic [7:0]  pos_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] idx_ff, end_ff;
   logic [CW-1:0] pend_idx_ff;
   logic        pend_ff;
   logic        hit_ff;
   logic [63:0] rd_data_ff;
   logic [63:0] acc_ff;
   logic [8:0]  found_ff;
   logic [1:0]  status_ff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff;
   logic [8:0]  rsp_found_ff;
   logic [8:0]  rsp_count_ff;
   logic [1:0]  rsp_status_ff;

   logic        in_rng, full, can_issue, out_free;
   logic        mem_we;
   logic [IW-1:0] mem_wa;
   logic [63:0] mem_wd;

   always_comb begin
      in_rng    = 32'(pos_ff) < 32'(count_ff);
      full      = count_ff == CW'(ble_pkg::CAPACITY);
      can_issue = (idx_ff < end_ff) && !hit_ff;
      out_free  = !rsp_valid_ff || rsp_tready;

      stat.need_scan = (cmd_ff == ble_pkg::CMD_GET) || (cmd_ff == ble_pkg::CMD_FIND) ||
                       (cmd_ff == ble_pkg::CMD_MAX) || (cmd_ff == ble_pkg::CMD_ERASE);
      stat.is_erase  = (cmd_ff == ble_pkg::CMD_ERASE) && (status_ff == ble_pkg::ST_OK);
      stat.scan_done = !can_issue && !pend_ff;
      stat.out_free  = out_free;
   end

   // One write port: push at decode, move-down during an erase scan, zeroing at fixup.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = count_ff[IW-1:0];
      mem_wd = value_ff;
      if (ctl.decode && cmd_ff == ble_pkg::CMD_PUSH && !full) begin
         mem_we = 1'b1;
      end else if (ctl.scan && pend_ff && cmd_ff == ble_pkg::CMD_ERASE) begin
         mem_we = 1'b1;
         mem_wa = IW'(pend_idx_ff - CW'(1));
         mem_wd = rd_data_ff;
      end else if (ctl.fixup) begin
         mem_we = 1'b1;
         mem_wa = IW'(count_ff - CW'(1));
         mem_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= ctl.scan && can_issue;
         if (ctl.decode) begin
            case (cmd_ff)
               ble_pkg::CMD_PUSH:  if (!full) count_ff <= count_ff + CW'(1);
               ble_pkg::CMD_POP:   if (count_ff != '0) count_ff <= count_ff - CW'(1);
               ble_pkg::CMD_CLEAR: count_ff <= '0;
               default:            count_ff <= count_ff;
            endcase
         end else if (ctl.fixup) begin
            count_ff <= count_ff - CW'(1);
         end
         if (ctl.respond && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= ble_pkg::cmd_type'(command);
         value_ff <= data_value;
         pos_ff   <= position;
      end
      if (ctl.decode) begin
         status_ff <= ble_pkg::ST_OK;
         acc_ff    <= '0;
         found_ff  <= '0;
         hit_ff    <= 1'b0;
         idx_ff    <= '0;
         end_ff    <= '0;
         case (cmd_ff)
            ble_pkg::CMD_PUSH: begin
               if (full) status_ff <= ble_pkg::ST_FULL;
            end
            ble_pkg::CMD_POP: begin
               if (count_ff == '0) status_ff <= ble_pkg::ST_RANGE;
            end
            ble_pkg::CMD_GET: begin
               if (in_rng) begin
                  idx_ff <= CW'(pos_ff);
                  end_ff <= CW'(pos_ff) + CW'(1);
               end else begin
                  status_ff <= ble_pkg::ST_RANGE;
               end
            end
            ble_pkg::CMD_FIND: begin
               found_ff <= '1;
               end_ff   <= count_ff;
            end
            ble_pkg::CMD_MAX: begin
               end_ff <= count_ff;
               if (count_ff == '0) begin
                  acc_ff    <= ble_pkg::INT_MIN_64;
                  status_ff <= ble_pkg::ST_RANGE;
               end
            end
            ble_pkg::CMD_ERASE: begin
               if (in_rng) begin
                  idx_ff <= CW'(pos_ff) + CW'(1);
                  end_ff <= count_ff;
               end else begin
                  status_ff <= ble_pkg::ST_RANGE;
               end
            end
            default: begin
               status_ff <= ble_pkg::ST_OK;
            end
         endcase
      end
      if (ctl.scan) begin
         if (can_issue) idx_ff <= idx_ff + CW'(1);
         pend_idx_ff <= idx_ff;
         if (pend_ff) begin
            case (cmd_ff)
               ble_pkg::CMD_GET: acc_ff <= rd_data_ff;
               ble_pkg::CMD_FIND: begin
                  if (!hit_ff && rd_data_ff == value_ff) begin
                     hit_ff   <= 1'b1;
                     found_ff <= 9'(pend_idx_ff);
                  end
               end
               ble_pkg::CMD_MAX: begin
                  if (pend_idx_ff == '0 || $signed(rd_data_ff) > $signed(acc_ff)) begin
                     acc_ff <= rd_data_ff;
                  end
               end
               default: acc_ff <= acc_ff;
            endcase
         end
      end
      if (ctl.respond && out_free) begin
         rsp_value_ff  <= acc_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= 9'(count_ff);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign read_value  = rsp_value_ff;
   assign found_index = rsp_found_ff;
   assign entry_count = rsp_count_ff;
   assign status      = rsp_status_ff;

endmodule

// ===== hdl/bounded_list_engine_core.sv =====
// Top level of the bounded list engine: beat packing and controller/datapath assembly.
//
// The block keeps an ordered list of up to 256 signed 64-bit entries and runs one command
// per request beat: push, pop, get, find, max, erase or clear. Each request beat yields
// exactly one response beat carrying the read value, the found index, the entry count
// after the command and a status code.
// Push, pop and clear go from decode straight to the response state. Get, find, max
// and erase pass through a scan state, which ends at once when there is nothing to walk
// (index out of range or empty list). Get walks one entry. Find and max walk the N stored
// entries through the single read port of the entry memory, one per cycle; find stops at
// the first match. Erase moves the entries above the erased one down by one, reading and
// writing one entry per cycle, then zeroes the freed top slot. The memory read port sets
// the scan speed. Only one command is in flight at a time; the block returns to idle and
// takes a new request beat once the previous response sits in the output register, even
// if the receiver has not taken it. When the receiver stalls with a response still held,
// the next command finishes its work and then waits until the held beat is taken.
// Reset empties the list and drops any pending response; entry contents are not cleared.
module bounded_list_engine_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // command [2:0], data_value [66:3], position [74:67], zero fill above
   input  logic [ble_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // read_value [63:0], found_index [72:64], entry_count [81:73], status [83:82], zero fill
   output logic [ble_pkg::RSP_W-1:0]   rsp_tdata
);

   ble_pkg::ctl_cmd_type ctl;
   ble_pkg::dp_stat_type stat;

   logic [2:0]  command;
   logic [63:0] data_value;
   logic [7:0]  position;
   logic [63:0] read_value;
   logic [8:0]  found_index;
   logic [8:0]  entry_count;
   logic [1:0]  status;

   // Split the request beat into its fields.
   assign command    = req_tdata[2:0];
   assign data_value = req_tdata[66:3];
   assign position   = req_tdata[74:67];

   // Pack the response fields, lowest field in the lowest bits.
   assign rsp_tdata = {4'b0, status, entry_count, found_index, read_value};

   ble_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   ble_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .stat        (stat),
      .command     (command),
      .data_value  (data_value),
      .position    (position),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .read_value  (read_value),
      .found_index (found_index),
      .entry_count (entry_count),
      .status      (status)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the bounded list engine: random command streams against a list model.
`timescale 1ns / 100ps

module tb;

   // Command code 7 is not part of the command set; the block must treat it as a no-op.
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   // The directed part comes first, then this many random commands on top of it.
   localparam int RANDOM_ITEMS = 1250;

   // One queued command, as the sender will put it on the request channel.
   typedef struct {
      logic [2:0]  op;
      logic [63:0] value;
      logic [7:0]  pos;
      bit          drain_first;  // hold this beat back until every response is in
   } list_req_t;

   // One response beat, split into its fields.
   typedef struct {
      logic [63:0] read_value;
      logic [8:0]  found_index;
      logic [8:0]  entry_count;
      logic [1:0]  status;
   } list_result_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // command [2:0], data_value [66:3], position [74:67], zero fill above
   logic [ble_pkg::REQ_W-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // read_value [63:0], found_index [72:64], entry_count [81:73], status [83:82], zero fill
   logic [ble_pkg::RSP_W-1:0] rsp_tdata;

   bounded_list_engine_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // List model. It holds its own copy of the entries and the count and is advanced once
   // for every request beat that the block accepts.
   // ---------------------------------------------------------------------------------------
   logic [63:0]  list_entries [ble_pkg::CAPACITY];
   int           list_len = 0;
   list_result_t results_due [$];
   int           mismatch_count = 0;

   task automatic run_list_command(input logic [2:0] op, input logic [63:0] val,
                                   input logic [7:0] pos, output list_result_t res);
      logic [63:0] best;
      int          k;
      res.read_value  = '0;
      res.found_index = '0;
      res.status      = ble_pkg::ST_OK;
      case (op)
         ble_pkg::CMD_PUSH: begin
            if (list_len >= ble_pkg::CAPACITY) begin
               res.status = ble_pkg::ST_FULL;
            end else begin
               list_entries[list_len] = val;
               list_len++;
            end
         end
         ble_pkg::CMD_POP: begin
            if (list_len > 0) begin
               list_len--;
            end else begin
               res.status = ble_pkg::ST_RANGE;
            end
         end
         ble_pkg::CMD_GET: begin
            if (int'(pos) < list_len) begin
               res.read_value = list_entries[pos];
            end else begin
               res.status = ble_pkg::ST_RANGE;
            end
         end
         ble_pkg::CMD_FIND: begin
            // All ones is -1 in the 9-bit index: nothing matched.
            res.found_index = '1;
            for (k = 0; k < list_len; k++) begin
               if (list_entries[k] == val) begin
                  res.found_index = 9'(k);
                  break;
               end
            end
         end
         ble_pkg::CMD_MAX: begin
            if (list_len == 0) begin
               res.read_value = ble_pkg::INT_MIN_64;
               res.status     = ble_pkg::ST_RANGE;
            end else begin
               best = list_entries[0];
               for (k = 1; k < list_len; k++) begin
                  if ($signed(list_entries[k]) > $signed(best)) begin
                     best = list_entries[k];
                  end
               end
               res.read_value = best;
            end
         end
         ble_pkg::CMD_ERASE: begin
            // Later entries move down one slot and the slot left free at the top reads zero.
            if (int'(pos) < list_len) begin
               for (k = int'(pos); k + 1 < list_len; k++) begin
                  list_entries[k] = list_entries[k + 1];
               end
               list_len--;
               list_entries[list_len] = '0;
            end else begin
               res.status = ble_pkg::ST_RANGE;
            end
         end
         ble_pkg::CMD_CLEAR: begin
            list_len = 0;
         end
         default: begin
         end
      endcase
      res.entry_count = 9'(list_len);
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected %h, got %h", $time, what, want, got);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus generation. The generator keeps a rough count of the list so that positions
   // mostly land inside it, and a pool of recently pushed values so that find hits often
   // and duplicate values exercise the first-match rule.
   // ---------------------------------------------------------------------------------------
   list_req_t   cmd_backlog [$];
   int          gen_len = 0;
   int          total_items = 0;
   logic [63:0] recent_values [$];

   task automatic add_item(input logic [2:0] op, input logic [63:0] val,
                           input logic [7:0] pos, input bit drain_first);
      list_req_t item;
      item.op          = op;
      item.value       = val;
      item.pos         = pos;
      item.drain_first = drain_first;
      cmd_backlog.push_back(item);
      total_items++;
      case (op)
         ble_pkg::CMD_PUSH: begin
            if (gen_len < ble_pkg::CAPACITY) begin
               gen_len++;
               recent_values.push_back(val);
               if (recent_values.size() > 32) begin
                  void'(recent_values.pop_front());
               end
            end
         end
         ble_pkg::CMD_POP: begin
            if (gen_len > 0) begin
               gen_len--;
            end
         end
         ble_pkg::CMD_ERASE: begin
            if (int'(pos) < gen_len) begin
               gen_len--;
            end
         end
         ble_pkg::CMD_CLEAR: begin
            gen_len = 0;
         end
         default: begin
         end
      endcase
   endtask

   // Values: a share of signed extremes, a share of repeats, the rest fully random.
   function automatic logic [63:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 6))
            0:       return 64'h8000_0000_0000_0000;
            1:       return 64'h7FFF_FFFF_FFFF_FFFF;
            2:       return 64'h0;
            3:       return 64'hFFFF_FFFF_FFFF_FFFF;
            4:       return ble_pkg::INT_MIN_64;
            5:       return 64'h0000_0000_7FFF_FFFF;
            default: return 64'h1;
         endcase
      end
      if (r < 40 && recent_values.size() != 0) begin
         return recent_values[$urandom_range(0, recent_values.size() - 1)];
      end
      return {$urandom, $urandom};
   endfunction

   // A search key: usually something that was pushed lately.
   function automatic logic [63:0] pick_probe();
      if (recent_values.size() != 0 && $urandom_range(0, 99) < 60) begin
         return recent_values[$urandom_range(0, recent_values.size() - 1)];
      end
      return pick_value();
   endfunction

   // Positions: mostly inside the list, sometimes just past its end, sometimes anywhere.
   function automatic logic [7:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (gen_len != 0 && r < 80) begin
         return 8'($urandom_range(0, gen_len - 1));
      end
      if (r < 88) begin
         return (gen_len > 255) ? 8'd255 : 8'(gen_len);
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Command mix; a draining segment favors pop and erase so that the list shrinks again.
   function automatic logic [2:0] pick_op(input bit draining);
      int r;
      r = $urandom_range(0, 99);
      if (draining) begin
         if (r < 10) return ble_pkg::CMD_PUSH;
         else if (r < 35) return ble_pkg::CMD_POP;
         else if (r < 45) return ble_pkg::CMD_GET;
         else if (r < 55) return ble_pkg::CMD_FIND;
         else if (r < 62) return ble_pkg::CMD_MAX;
         else if (r < 95) return ble_pkg::CMD_ERASE;
         else if (r < 97) return ble_pkg::CMD_CLEAR;
         else return CMD_UNUSED;
      end
      if (r < 38) return ble_pkg::CMD_PUSH;
      else if (r < 46) return ble_pkg::CMD_POP;
      else if (r < 62) return ble_pkg::CMD_GET;
      else if (r < 76) return ble_pkg::CMD_FIND;
      else if (r < 84) return ble_pkg::CMD_MAX;
      else if (r < 95) return ble_pkg::CMD_ERASE;
      else if (r < 97) return ble_pkg::CMD_CLEAR;
      else return CMD_UNUSED;
   endfunction

   task automatic build_stimulus();
      int          seg;
      int          seg_len;
      bit          draining;
      logic [2:0]  op;
      // Directed part. An empty list first: every command that needs an entry must
      // report the range status, and max must return the 32-bit minimum sentinel.
      add_item(ble_pkg::CMD_POP,   64'h0, 8'd0, 1'b0);
      add_item(ble_pkg::CMD_GET,   64'h0, 8'd0, 1'b0);
      add_item(ble_pkg::CMD_MAX,   64'h0, 8'd0, 1'b0);
      add_item(ble_pkg::CMD_FIND,  64'h0, 8'd0, 1'b0);
      add_item(ble_pkg::CMD_ERASE, 64'h0, 8'd0, 1'b0);
      // Signed extremes, the sentinel value itself as data, and a duplicate.
      add_item(ble_pkg::CMD_PUSH,  64'h8000_0000_0000_0000, 8'hFF, 1'b0);
      add_item(ble_pkg::CMD_PUSH,  64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 1'b0);
      add_item(ble_pkg::CMD_PUSH,  64'h0, 8'h00, 1'b0);
      add_item(ble_pkg::CMD_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0);
      add_item(ble_pkg::CMD_PUSH,  ble_pkg::INT_MIN_64, 8'h00, 1'b0);
      add_item(ble_pkg::CMD_PUSH,  64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 1'b0);
      add_item(ble_pkg::CMD_GET,   64'h0, 8'd0, 1'b0);
      add_item(ble_pkg::CMD_GET,   64'h0, 8'd5, 1'b0);
      add_item(ble_pkg::CMD_GET,   64'h0, 8'd6, 1'b0);
      // The duplicate must be found at its first index; an absent key gives -1.
      add_item(ble_pkg::CMD_FIND,  64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 1'b0);
      add_item(ble_pkg::CMD_FIND,  64'h0000_0000_0000_1234, 8'd0, 1'b0);
      add_item(ble_pkg::CMD_MAX,   64'h0, 8'd0, 1'b0);
      // Erase from the middle, then the last entry, then past the end.
      add_item(ble_pkg::CMD_ERASE, 64'h0, 8'd1, 1'b0);
      add_item(ble_pkg::CMD_GET,   64'h0, 8'd1, 1'b0);
      add_item(ble_pkg::CMD_ERASE, 64'h0, 8'd4, 1'b0);
      add_item(ble_pkg::CMD_ERASE, 64'h0, 8'd255, 1'b0);
      add_item(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0);
      add_item(ble_pkg::CMD_POP,   64'h0, 8'd0, 1'b0);
      // Clear once the pipe has drained, then max on the empty list again.
      add_item(ble_pkg::CMD_CLEAR, 64'h0, 8'd0, 1'b1);
      add_item(ble_pkg::CMD_MAX,   64'h0, 8'd0, 1'b0);
      add_item(ble_pkg::CMD_PUSH,  64'h5, 8'd0, 1'b0);

      // Random part in segments. Every fifth segment fills the list to capacity and then
      // pushes into the full list; the others mix commands with random content.
      seg = 0;
      while (total_items < 26 + RANDOM_ITEMS) begin
         if (seg % 5 == 1) begin
            add_item(ble_pkg::CMD_CLEAR, pick_value(), pick_position(),
                     1'($urandom_range(0, 1)));
            while (gen_len < ble_pkg::CAPACITY) begin
               if ($urandom_range(0, 9) == 0) begin
                  op = ($urandom_range(0, 1) != 0) ? ble_pkg::CMD_GET : ble_pkg::CMD_FIND;
                  add_item(op, pick_probe(), pick_position(), 1'b0);
               end else begin
                  add_item(ble_pkg::CMD_PUSH, pick_value(), pick_position(), 1'b0);
               end
            end
            repeat (3) add_item(ble_pkg::CMD_PUSH, pick_value(), pick_position(), 1'b0);
            add_item(ble_pkg::CMD_MAX, pick_value(), pick_position(), 1'b0);
         end else begin
            draining = (gen_len > 200) || ($urandom_range(0, 3) == 0);
            seg_len  = $urandom_range(20, 120);
            for (int n = 0; n < seg_len; n++) begin
               op = pick_op(draining);
               add_item(op, (op == ble_pkg::CMD_FIND) ? pick_probe() : pick_value(),
                        pick_position(), (n == 0) && ($urandom_range(0, 3) == 0));
            end
         end
         seg++;
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Request driver. It sends in bursts of random length with random gaps between them;
   // now and then a long burst with no gaps. A beat marked drain_first waits until every
   // response owed has come back. The model is advanced at each accepting edge, with the
   // fields taken from the beat that was actually on the bus.
   // ---------------------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;
   int accepted_reqs = 0;

   always @(posedge clock) begin
      list_result_t res;
      list_req_t    nxt;
      bit           offer;
      if (reset) begin
         req_tvalid   <= 1'b0;
         req_tdata    <= '0;
         list_len      = 0;
         burst_left    = 0;
         gap_left      = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            run_list_command(req_tdata[2:0], req_tdata[66:3], req_tdata[74:67], res);
            results_due.push_back(res);
            accepted_reqs <= accepted_reqs + 1;
         end
         // The bus is free for a new beat unless the current one is still waiting.
         if (!req_tvalid || req_tready) begin
            offer = 1'b0;
            if (gap_left != 0) begin
               gap_left--;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain_first && results_due.size() != 0)) begin
               nxt   = cmd_backlog.pop_front();
               offer = 1'b1;
               if (burst_left <= 1) begin
                  if ($urandom_range(0, 9) == 0) begin
                     burst_left = 300;
                     gap_left   = 0;
                  end else begin
                     burst_left = $urandom_range(1, 40);
                     gap_left   = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 12) : 0;
                  end
               end else begin
                  burst_left--;
               end
            end
            req_tvalid <= offer;
            if (offer) begin
               req_tdata <= {5'b0, nxt.pos, nxt.value, nxt.op};
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Response side. The ready pattern changes mode every so often: always ready, mostly
   // ready, mostly stalled, or a fixed toggle. A separate counter imposes two long
   // hold-offs while the sender keeps offering, so that the held response backs the
   // block up and it stops taking request beats.
   // ---------------------------------------------------------------------------------------
   int hold_cycles = 0;
   int holds_done  = 0;

   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         holds_done  <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (holds_done < 2 && accepted_reqs >= 300 + 500 * holds_done) begin
         hold_cycles <= 800;
         holds_done  <= holds_done + 1;
      end
   end

   int ready_mode = 0;
   int ready_run  = 0;

   always @(posedge clock) begin
      logic rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_run   = 0;
      end else begin
         if (ready_run == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_run  = $urandom_range(20, 400);
         end
         ready_run--;
         case (ready_mode)
            0:       rdy = 1'b1;
            1:       rdy = ($urandom_range(0, 9) < 7);
            2:       rdy = ($urandom_range(0, 9) < 3);
            default: rdy = ready_run[2];
         endcase
         rsp_tready <= rdy && (hold_cycles == 0);
      end
   end

   // Response checker: each accepted beat is compared field by field with the oldest
   // expectation.
   always @(posedge clock) begin
      list_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            note_mismatch("response beat with nothing outstanding", 64'h0, rsp_tdata[63:0]);
         end else begin
            want = results_due.pop_front();
            if (rsp_tdata[63:0] !== want.read_value)
               note_mismatch("read_value", want.read_value, rsp_tdata[63:0]);
            if (rsp_tdata[72:64] !== want.found_index)
               note_mismatch("found_index", 64'(want.found_index), 64'(rsp_tdata[72:64]));
            if (rsp_tdata[81:73] !== want.entry_count)
               note_mismatch("entry_count", 64'(want.entry_count), 64'(rsp_tdata[81:73]));
            if (rsp_tdata[83:82] !== want.status)
               note_mismatch("status", 64'(want.status), 64'(rsp_tdata[83:82]));
         end
      end
   end

   // Main sequence: build the command list, hold reset, let everything drain, judge.
   initial begin
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (cmd_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      // A full-length scan is the slowest command; wait past it for any stray beat.
      repeat (2 * ble_pkg::CAPACITY + 50) @(posedge clock);
      if (mismatch_count == 0 && results_due.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, with every command a full scan,
   // every beat held through the longest stall and both long hold-offs.
   initial begin
      #50_000_000;
      $display("tb failed");
      $finish;
   end

endmodule
